// ----- hw/rtl/nand_page_read_sequencer_unit_macros.svh -----
// Assertion helpers for the NAND page read sequencer.
// Both sample on clk and are switched off while rst_n is low.
`ifndef NAND_PAGE_READ_SEQUENCER_UNIT_MACROS_SVH
`define NAND_PAGE_READ_SEQUENCER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle.
`define NPR_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the next cycle.
`define NPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/npr_pkg.sv -----
`default_nettype none

package npr_pkg;

    // input action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_READY = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_SEL = 3'd0;
    localparam logic [2:0] KIND_CMD = 3'd1;
    localparam logic [2:0] KIND_ADR = 3'd2;
    localparam logic [2:0] KIND_DAT = 3'd3;
    localparam logic [2:0] KIND_DES = 3'd4;

    // flash commands
    localparam logic [7:0] CMD_READ    = 8'h00;
    localparam logic [7:0] CMD_CONFIRM = 8'h30;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    // what follows the head result of a burst
    typedef enum logic [2:0] {
        TAIL_NONE = 3'b001,
        TAIL_DES  = 3'b010,
        TAIL_PAGE = 3'b100
    } tail_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nand_page_read_sequencer_unit.sv -----
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       s_tuser action, s_tdata address/length/byte
// m_*       out  m_tvalid / m_tready       m_tuser kind, m_tdata byte/index, m_tlast
//
// A ready event, an ignored item or a plain data byte keeps s_tready high while the
// output is not stalled by m_tready, and data bytes then stream at one per cycle.
// A start, or a byte that closes a page or the read, opens a burst of up to eight
// results; the burst emitter sends one per cycle unless m_tready stalls it, and
// holds s_tready low until its final result is loaded into the output register.
// Reset clears the phase, counters and both valid flags; no clearing pass is needed.
// A stall on m_tready freezes the emitter; the output register parts the two sides.
`default_nettype none

`include "nand_page_read_sequencer_unit_macros.svh"

module nand_page_read_sequencer_unit
    import npr_pkg::*;
#(
    // bytes per flash page, a power of two
    parameter int unsigned PAGE_BYTES = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    input  wire logic [63:0] s_tdata,   // [31:0] start_address, [55:32] read_length,
                                        // [63:56] flash_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic [31:0]      m_tdata,   // [7:0] bus_byte, [31:8] byte_index
    output logic             m_tlast    // last result of the input transaction
);

    localparam int unsigned PAGE_W = $clog2(PAGE_BYTES);

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [31:0] read_pointer_reg, read_pointer_next;
    logic [23:0] bytes_done_reg, bytes_done_next;
    logic [23:0] bytes_wanted_reg, bytes_wanted_next;

    // burst descriptor
    logic        burst_valid_reg, burst_valid_next;
    logic        head_data_reg, head_data_next;
    tail_t       tail_reg, tail_next;
    logic [7:0]  head_byte_reg, head_byte_next;
    logic [23:0] head_index_reg, head_index_next;
    logic [2:0]  step_reg, step_next;

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic [23:0] out_index_reg;
    logic        out_last_reg;

    logic        out_load;
    logic        last_step;
    logic        burst_done;
    logic        in_accept;
    logic [2:0]  last_idx;
    logic [23:0] done_inc;
    logic        page_end;
    logic [15:0] col_word;
    logic [31:0] page_word;
    logic [2:0]  emit_kind;
    logic [7:0]  emit_byte;
    logic [23:0] emit_index;

    logic [31:0] in_address;
    logic [23:0] in_length;
    logic [7:0]  in_byte;

    assign in_address = s_tdata[31:0];
    assign in_length  = s_tdata[55:32];
    assign in_byte    = s_tdata[63:56];

    // burst length less one
    always_comb
    begin
        unique case (tail_reg)
            TAIL_NONE: last_idx = 3'd0;
            TAIL_DES:  last_idx = 3'd1;
            TAIL_PAGE: last_idx = 3'd7;
            default:   last_idx = 3'd0;
        endcase
    end

    assign out_load   = burst_valid_reg && (!out_valid_reg || m_tready);
    assign last_step  = (step_reg == last_idx);
    assign burst_done = out_load && last_step;
    assign s_tready   = !burst_valid_reg || burst_done;
    assign in_accept  = s_tvalid && s_tready;

    assign done_inc = bytes_done_reg + 24'd1;
    assign page_end = &read_pointer_reg[PAGE_W-1:0];

    // column and page of the pointer, already advanced when a page burst follows a data byte
    assign col_word  = 16'(read_pointer_reg[PAGE_W-1:0]);
    assign page_word = read_pointer_reg >> PAGE_W;

    // accept side: state update and burst set-up
    always_comb
    begin
        phase_next        = phase_reg;
        read_pointer_next = read_pointer_reg;
        bytes_done_next   = bytes_done_reg;
        bytes_wanted_next = bytes_wanted_reg;
        head_data_next    = head_data_reg;
        tail_next         = tail_reg;
        head_byte_next    = head_byte_reg;
        head_index_next   = head_index_reg;
        burst_valid_next  = burst_valid_reg && !burst_done;
        step_next         = out_load ? step_reg + 3'd1 : step_reg;

        if (in_accept)
        begin
            if (s_tuser == ACT_START && phase_reg == PH_IDLE)
            begin
                read_pointer_next = in_address;
                bytes_wanted_next = in_length;
                bytes_done_next   = '0;
                burst_valid_next  = 1'b1;
                step_next         = '0;
                head_data_next    = 1'b0;
                head_byte_next    = '0;
                head_index_next   = '0;
                if (in_length == '0)
                begin
                    tail_next = TAIL_DES;
                end
                else
                begin
                    tail_next  = TAIL_PAGE;
                    phase_next = PH_WAIT;
                end
            end
            else if (s_tuser == ACT_READY && phase_reg == PH_WAIT)
            begin
                phase_next = PH_DATA;
            end
            else if (s_tuser == ACT_DATA && phase_reg == PH_DATA)
            begin
                read_pointer_next = read_pointer_reg + 32'd1;
                bytes_done_next   = done_inc;
                burst_valid_next  = 1'b1;
                step_next         = '0;
                head_data_next    = 1'b1;
                head_byte_next    = in_byte;
                head_index_next   = bytes_done_reg;
                if (done_inc == bytes_wanted_reg)
                begin
                    tail_next  = TAIL_DES;
                    phase_next = PH_IDLE;
                end
                else if (page_end)
                begin
                    // next page needs its command and address again
                    tail_next  = TAIL_PAGE;
                    phase_next = PH_WAIT;
                end
                else
                begin
                    tail_next = TAIL_NONE;
                end
            end
        end
    end

    // emit side: result for the current burst step
    always_comb
    begin
        emit_kind  = KIND_SEL;
        emit_byte  = '0;
        emit_index = '0;
        if (step_reg == 3'd0)
        begin
            if (head_data_reg)
            begin
                emit_kind  = KIND_DAT;
                emit_byte  = head_byte_reg;
                emit_index = head_index_reg;
            end
        end
        else if (tail_reg == TAIL_DES)
        begin
            emit_kind = KIND_DES;
        end
        else
        begin
            case (step_reg)
                3'd1:
                begin
                    emit_kind = KIND_CMD;
                    emit_byte = CMD_READ;
                end
                3'd2:
                begin
                    emit_kind = KIND_ADR;
                    emit_byte = col_word[7:0];
                end
                3'd3:
                begin
                    emit_kind = KIND_ADR;
                    emit_byte = col_word[15:8];
                end
                3'd4:
                begin
                    emit_kind = KIND_ADR;
                    emit_byte = page_word[7:0];
                end
                3'd5:
                begin
                    emit_kind = KIND_ADR;
                    emit_byte = page_word[15:8];
                end
                3'd6:
                begin
                    emit_kind = KIND_ADR;
                    emit_byte = page_word[23:16];
                end
                default:
                begin
                    emit_kind = KIND_CMD;
                    emit_byte = CMD_CONFIRM;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            read_pointer_reg <= '0;
            bytes_done_reg   <= '0;
            bytes_wanted_reg <= '0;
            burst_valid_reg  <= 1'b0;
            step_reg         <= '0;
            tail_reg         <= TAIL_NONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            read_pointer_reg <= read_pointer_next;
            bytes_done_reg   <= bytes_done_next;
            bytes_wanted_reg <= bytes_wanted_next;
            burst_valid_reg  <= burst_valid_next;
            step_reg         <= step_next;
            tail_reg         <= tail_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        head_data_reg  <= head_data_next;
        head_byte_reg  <= head_byte_next;
        head_index_reg <= head_index_next;
        if (out_load)
        begin
            out_kind_reg  <= emit_kind;
            out_byte_reg  <= emit_byte;
            out_index_reg <= emit_index;
            out_last_reg  <= last_step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_index_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

    // deselect always closes the results of its transaction
    `NPR_ASSERT_HOLDS(a_des_is_last, m_tvalid && m_tuser == KIND_DES, m_tlast,
        "deselect result without last")
    // an accepted start opens a select burst at step zero
    `NPR_ASSERT_NEXT(a_start_opens_burst,
        in_accept && s_tuser == ACT_START && phase_reg == PH_IDLE,
        burst_valid_reg && step_reg == 3'd0 && !head_data_reg,
        "start did not open a select burst")
    // a stalled output freezes the burst emitter
    `NPR_ASSERT_NEXT(a_step_holds_on_stall,
        burst_valid_reg && out_valid_reg && !m_tready,
        burst_valid_reg && $stable(step_reg),
        "burst advanced while output stalled")

endmodule

`default_nettype wire
